### hw/rtl/akm_pkg.sv
// ----------------------------------------------------------------------------
// akm_pkg
// shared widths, register indexes and bundle types of the keyword matcher
// ----------------------------------------------------------------------------
package akm_pkg;

	localparam int CHAR_W                  = 8;
	localparam int KW_W                    = 64;
	localparam int LEN_W                   = 4;
	localparam int CNT_W                   = 4;
	localparam int CFG_IDX_W               = 2;
	localparam int DEFAULT_MAX_KEYWORD_LEN = 8;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_KEYWORD_BYTES  = 2'd0;
	localparam cfg_idx_t REG_KEYWORD_LENGTH = 2'd1;
	localparam cfg_idx_t REG_MATCH_FLOOR    = 2'd2;

	typedef struct packed {
		logic [KW_W-1:0]  keyword_bytes;
		logic [LEN_W-1:0] eff_len;
		logic [LEN_W-1:0] match_floor;
	} cfg_t;

	typedef struct packed {
		logic              fire;
		logic              last;
		logic [CHAR_W-1:0] quote_char;
	} beat_t;

endpackage

### hw/rtl/approximate_keyword_matcher.sv
// ----------------------------------------------------------------------------
// approximate_keyword_matcher
// hamming-threshold keyword search over a streamed quote, one flag per quote
// ----------------------------------------------------------------------------
// result path: an accepted last beat is registered in the input stage, then its flag in the output register
// throughput: one quote byte per cycle while no last beat is stalled, set by the per-beat window update
// a result waiting in the output register stalls only a following last beat
// reset: asynchronous, clears registers, windows, hit flag and both valids
// ----------------------------------------------------------------------------
module approximate_keyword_matcher #(
	parameter int unsigned MAX_KEYWORD_LEN = akm_pkg::DEFAULT_MAX_KEYWORD_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [akm_pkg::CHAR_W-1:0]    s_axis_tdata,  // quote_char
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // found, zero fill
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [akm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [akm_pkg::KW_W-1:0]      cfg_data
);
	import akm_pkg::*;

	cfg_t              cfg;
	beat_t             beat;
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              advance_s1;
	logic              found;
	logic              out_valid_q;
	logic              found_q;
	logic              in_fire;

	assign cfg_ready = 1'b1;

	akm_cfg_regs #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance_s1    = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign beat.fire       = advance_s1;
	assign beat.last       = last_s1;
	assign beat.quote_char = char_s1;

	akm_window_bank #(
		.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
	) u_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.beat  (beat),
		.found (found)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			found_q <= found;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, found_q};

	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> valid_s1)
		else $error("accepted beat missing from input stage");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && last_s1) |=> m_axis_tvalid && (m_axis_tdata[0] == $past(found)))
		else $error("result of last beat not presented");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && last_s1) |-> (!out_valid_q || m_axis_tready))
		else $error("pending result overwritten");

endmodule

### hw/rtl/akm_cfg_regs.sv
// ----------------------------------------------------------------------------
// akm_cfg_regs
// keyword, length and floor registers with length saturation
// ----------------------------------------------------------------------------
module akm_cfg_regs #(
	parameter int unsigned MAX_KEYWORD_LEN = akm_pkg::DEFAULT_MAX_KEYWORD_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [akm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [akm_pkg::KW_W-1:0]      cfg_data,
	output akm_pkg::cfg_t                cfg
);
	import akm_pkg::*;

	logic [KW_W-1:0]  keyword_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_q <= '0;
			length_q  <= '0;
			floor_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEYWORD_BYTES:  keyword_q <= cfg_data;
				REG_KEYWORD_LENGTH: length_q  <= cfg_data[LEN_W-1:0];
				REG_MATCH_FLOOR:    floor_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.keyword_bytes = keyword_q;
		cfg.match_floor   = floor_q;
		if (length_q > LEN_W'(MAX_KEYWORD_LEN)) begin
			cfg.eff_len = LEN_W'(MAX_KEYWORD_LEN);
		end else begin
			cfg.eff_len = length_q;
		end
	end

endmodule

### hw/rtl/akm_window_bank.sv
// ----------------------------------------------------------------------------
// akm_window_bank
// one match counter per open window, all windows aged and updated per beat
// ----------------------------------------------------------------------------
module akm_window_bank #(
	parameter int unsigned MAX_KEYWORD_LEN = akm_pkg::DEFAULT_MAX_KEYWORD_LEN
) (
	input  logic           clk,
	input  logic           arst_n,
	input  akm_pkg::cfg_t  cfg,
	input  akm_pkg::beat_t beat,
	output logic           found
);
	import akm_pkg::*;

	logic [MAX_KEYWORD_LEN-1:0] valid_q;
	logic [CNT_W-1:0]           cnt_q [MAX_KEYWORD_LEN];
	logic                       hit_q;

	logic [MAX_KEYWORD_LEN-1:0] valid_d;
	logic [CNT_W-1:0]           cnt_d [MAX_KEYWORD_LEN];
	logic [MAX_KEYWORD_LEN-1:0] hit_slot;
	logic [MAX_KEYWORD_LEN:0]   valid_ext;

	for (genvar i = 0; i < MAX_KEYWORD_LEN; i++) begin : g_slot
		logic             prev_valid;
		logic [CNT_W-1:0] prev_cnt;
		logic             inc;
		logic [CNT_W-1:0] cnt_new;
		logic             keep;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_cnt   = '0;
		end else begin : g_tail
			assign prev_valid = valid_q[i-1];
			assign prev_cnt   = cnt_q[i-1];
		end

		assign inc = (LEN_W'(i) < cfg.eff_len) &&
			(cfg.keyword_bytes[CHAR_W*i +: CHAR_W] == beat.quote_char);
		assign cnt_new     = prev_cnt + CNT_W'(inc);
		assign hit_slot[i] = prev_valid && (cnt_new > cfg.match_floor);
		assign keep        = prev_valid && (LEN_W'(i + 1) < cfg.eff_len);
		assign valid_d[i]  = keep;
		assign cnt_d[i]    = keep ? cnt_new : '0;
	end

	assign found = hit_q | (|hit_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
			for (int k = 0; k < MAX_KEYWORD_LEN; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (beat.fire) begin
			if (beat.last) begin
				valid_q <= '0;
				hit_q   <= 1'b0;
				for (int k = 0; k < MAX_KEYWORD_LEN; k++) begin
					cnt_q[k] <= '0;
				end
			end else begin
				valid_q <= valid_d;
				hit_q   <= found;
				for (int k = 0; k < MAX_KEYWORD_LEN; k++) begin
					cnt_q[k] <= cnt_d[k];
				end
			end
		end
	end

	assign valid_ext = {1'b0, valid_q};

	// open windows always form a run starting at the youngest slot
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_ext + (MAX_KEYWORD_LEN+1)'(1)) & valid_ext) == '0)
		else $error("window valid bits not a prefix");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(beat.fire && beat.last) |=> (valid_q == '0) && !hit_q)
		else $error("window state not cleared after last beat");

	a_hit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && !beat.fire) |=> hit_q)
		else $error("hit flag lost without a beat");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// streams quotes into the keyword matcher under random stalls on both sides,
// rewrites the keyword registers between phases and checks every found flag
// against a cycle-free model of the sliding match windows
// ----------------------------------------------------------------------------

class match_scoreboard;
	logic [63:0] kw_bytes;
	logic [3:0]  kw_len;
	logic [3:0]  floor_val;
	logic [3:0]  counts[8];
	bit          live[8];
	bit          hit;
	logic [7:0]  found_q[$];
	int          errors;

	function new();
		kw_bytes  = '0;
		kw_len    = '0;
		floor_val = '0;
		errors    = 0;
		clear_windows();
	endfunction

	function void clear_windows();
		int i;
		for (i = 0; i < 8; i++) begin
			counts[i] = '0;
			live[i]   = 1'b0;
		end
		hit = 1'b0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [63:0] data);
		if (idx == akm_pkg::REG_KEYWORD_BYTES) kw_bytes = data;
		else if (idx == akm_pkg::REG_KEYWORD_LENGTH) kw_len = data[3:0];
		else if (idx == akm_pkg::REG_MATCH_FLOOR) floor_val = data[3:0];
	endfunction

	function void take_char(logic [7:0] ch, logic lst);
		int i;
		int len;
		len = (kw_len > 8) ? 8 : int'(kw_len);
		for (i = 7; i > 0; i--) begin
			counts[i] = counts[i-1];
			live[i]   = live[i-1];
		end
		counts[0] = '0;
		live[0]   = 1'b1;
		for (i = 0; i < 8; i++) begin
			if (live[i]) begin
				if (i < len && kw_bytes[8*i +: 8] == ch) counts[i] = counts[i] + 4'd1;
				if (counts[i] > floor_val) hit = 1'b1;
				if (i + 1 >= len) begin
					live[i]   = 1'b0;
					counts[i] = '0;
				end
			end
		end
		if (lst) begin
			found_q.push_back({7'd0, hit});
			clear_windows();
		end
	endfunction

	function void check_found(logic [7:0] got);
		logic [7:0] want;
		if (found_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %0h", $time, got);
			errors++;
			return;
		end
		want = found_q.pop_front();
		if (got !== want) begin
			$display("%0t: found mismatch, expected %0h, actual %0h", $time, want, got);
			errors++;
		end
	endfunction
endclass

module tb;
	import akm_pkg::*;

	localparam cfg_idx_t REG_UNUSED   = 2'd3;
	localparam int       ITEM_TARGET  = 1150;
	localparam int       IDLE_LIMIT   = 1000;
	localparam int       DRAIN_CYCLES = 4;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;  // quote_char
	logic              s_axis_tlast;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;  // found, zero fill
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KW_W-1:0]   cfg_data;

	match_scoreboard sb = new();
	int stall_pct = 26;
	int items = 0;
	int idle_cycles = 0;
	logic [63:0] kw_dir;

	approximate_keyword_matcher uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) sb.take_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) sb.check_found(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic [7:0] noise_byte(logic [63:0] kw);
		if ($urandom_range(0, 1) == 0) return kw[8*$urandom_range(0, 7) +: 8];
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic lst);
		while ($urandom_range(0, 99) < stall_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		items++;
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [63:0] kw, input logic [3:0] len,
			input logic [3:0] fl, input bit stray);
		logic [63:0] d;
		write_cfg(REG_KEYWORD_BYTES, kw);
		d = {$urandom, $urandom};
		d[3:0] = len;
		write_cfg(REG_KEYWORD_LENGTH, d);
		d = {$urandom, $urandom};
		d[3:0] = fl;
		write_cfg(REG_MATCH_FLOOR, d);
		if (stray) write_cfg(REG_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	// hold the sender until all flags are back and the window pipe has settled
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.found_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_copy(input int n, input logic [7:0] flip, input logic lst);
		int j;
		for (j = 0; j < n; j++) begin
			send_char(kw_dir[8*j +: 8] ^ {8{flip[j]}}, lst && (j == n - 1));
		end
	endtask

	task automatic send_quote(input bit finish);
		logic [7:0] q[0:23];
		logic [63:0] kw;
		int n, k, len, j;
		bit cut;
		kw  = sb.kw_bytes;
		len = (sb.kw_len > 8) ? 8 : int'(sb.kw_len);
		n   = 0;
		if ($urandom_range(0, 9) < 7) begin
			k = $urandom_range(0, 4);
			for (j = 0; j < k; j++) begin
				q[n] = noise_byte(kw);
				n++;
			end
			k = (len == 0) ? $urandom_range(1, 8) : len;
			cut = ($urandom_range(0, 7) == 0);
			if (cut) k = $urandom_range(1, k);
			for (j = 0; j < k; j++) begin
				q[n] = kw[8*j +: 8];
				if ($urandom_range(0, 5) == 0) q[n] = noise_byte(kw);
				n++;
			end
			if (!cut) begin
				k = $urandom_range(0, 3);
				for (j = 0; j < k; j++) begin
					q[n] = noise_byte(kw);
					n++;
				end
			end
		end else begin
			k = $urandom_range(1, 12);
			for (j = 0; j < k; j++) begin
				q[n] = 8'($urandom_range(0, 255));
				n++;
			end
		end
		if (!finish) n = $urandom_range(1, n);
		for (j = 0; j < n; j++) send_char(q[j], finish && (j == n - 1));
	endtask

	task automatic random_config();
		logic [63:0] kw;
		int len, eff, fl;
		kw = ($urandom_range(0, 3) == 0) ? sb.kw_bytes : {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				len = 0;
			end
			1: begin
				len = $urandom_range(9, 15);
			end
			default: begin
				len = $urandom_range(1, 8);
			end
		endcase
		eff = (len > 8) ? 8 : len;
		case ($urandom_range(0, 5))
			0: begin
				fl = $urandom_range(0, 15);
			end
			1: begin
				fl = 8;
			end
			default: begin
				fl = eff - 1 - $urandom_range(0, 2);
				if (fl < 0) fl = 0;
			end
		endcase
		set_regs(kw, 4'(len), 4'(fl), $urandom_range(0, 5) == 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		kw_dir        = 64'h00ff_5a3c_7e81_00ff;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: zero length never matches
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b1);
		drain();

		set_regs(kw_dir, 4'd3, 4'd2, 1'b0);
		send_copy(3, 8'h00, 1'b1);
		send_copy(2, 8'h00, 1'b1);
		send_copy(3, 8'h02, 1'b1);
		drain();

		// length above the maximum saturates, stray index ignored
		set_regs(kw_dir, 4'd15, 4'd7, 1'b1);
		send_copy(8, 8'h00, 1'b1);
		drain();

		set_regs(kw_dir, 4'd8, 4'd8, 1'b0);
		send_copy(4, 8'h00, 1'b1);
		drain();

		// registers change while a quote is open
		set_regs(kw_dir, 4'd8, 4'd1, 1'b0);
		send_copy(2, 8'h00, 1'b0);
		drain();
		set_regs(kw_dir, 4'd1, 4'd0, 1'b0);
		send_char(kw_dir[7:0], 1'b1);
		drain();

		while (items < ITEM_TARGET) begin
			random_config();
			stall_pct = (items >= 450 && items < 650) ? 0 : 26;
			repeat ($urandom_range(2, 8)) send_quote(1'b1);
			if ($urandom_range(0, 3) == 0) send_quote(1'b0);
			drain();
		end

		send_quote(1'b1);
		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.found_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/akm_pkg.sv
hw/rtl/akm_cfg_regs.sv
hw/rtl/akm_window_bank.sv
hw/rtl/approximate_keyword_matcher.sv
tb/tb.sv
